FILE: design/omt_pkg.sv
// ----------------------------------------------------------------------------
// omt_pkg
// Shared types, codes and helper functions of the obstacle merge table.
// ----------------------------------------------------------------------------
package omt_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int SLOT_W          = 5;
  localparam int KIND_W          = 4;
  localparam int POS_W           = 16;
  localparam int STATUS_W        = 3;
  localparam int CMD_W           = 2;
  localparam int MUL_W           = 18;
  localparam int ACC_W           = 37;
  localparam int DIST_W          = 34;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INTEGRATE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROP_SELF = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROP_GOAL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DUMP      = 3'd6;

  // obstacle kinds
  localparam logic [KIND_W-1:0] K_UNKNOWN   = 4'd0;
  localparam logic [KIND_W-1:0] K_BALL      = 4'd1;
  localparam logic [KIND_W-1:0] K_GOAL      = 4'd2;
  localparam logic [KIND_W-1:0] K_ANON      = 4'd3;
  localparam logic [KIND_W-1:0] K_HOSTILE   = 4'd4;
  localparam logic [KIND_W-1:0] K_TEAM      = 4'd5;
  localparam logic [KIND_W-1:0] K_F_ANON    = 4'd6;
  localparam logic [KIND_W-1:0] K_F_HOSTILE = 4'd7;
  localparam logic [KIND_W-1:0] K_F_TEAM    = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECLASSIFY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLEN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_COS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_SIN  = 3'd6;

  typedef struct packed {
    logic               en;
    logic               clr;
    logic               sub;
    logic [MUL_W-1:0]   a;
    logic [MUL_W-1:0]   b;
  } mac_op_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  fx;
    logic [POS_W-1:0]  fy;
    logic [POS_W-1:0]  rx;
    logic [POS_W-1:0]  ry;
  } entry_t;

  function automatic logic [POS_W-1:0] sat17(input logic signed [POS_W:0] v);
    if (v > 17'sd32767) return 16'h7fff;
    if (v < -17'sd32768) return 16'h8000;
    return v[POS_W-1:0];
  endfunction

  // round half towards +inf at q14, then saturate
  function automatic logic [POS_W-1:0] round_q14(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0]  t;
    logic signed [ACC_W-15:0] q;
    t = p + ACC_W'(8192);
    q = t[ACC_W-1:14];
    if (q > (ACC_W-14)'(32767)) return 16'h7fff;
    if (q < -(ACC_W-14)'(32768)) return 16'h8000;
    return q[POS_W-1:0];
  endfunction

  function automatic logic as_specific(input logic [KIND_W-1:0] first,
                                       input logic [KIND_W-1:0] second,
                                       input logic recl);
    return (second == first) ||
           (recl && second == K_UNKNOWN && first != K_UNKNOWN && first != K_BALL) ||
           (second == K_ANON && (first == K_HOSTILE || first == K_TEAM)) ||
           (second == K_F_ANON && (first == K_F_HOSTILE || first == K_F_TEAM));
  endfunction

  // {ok, kind}
  function automatic logic [KIND_W:0] merge_kind(input logic [KIND_W-1:0] a,
                                                 input logic [KIND_W-1:0] b,
                                                 input logic recl);
    if (as_specific(a, b, recl)) return {1'b1, a};
    if (as_specific(b, a, recl)) return {1'b1, b};
    return {1'b0, K_UNKNOWN};
  endfunction

  function automatic logic may_be_self(input logic [KIND_W-1:0] k, input logic fallen);
    case (k)
      K_UNKNOWN:          return 1'b1;
      K_ANON, K_TEAM:     return !fallen;
      K_F_ANON, K_F_TEAM: return fallen;
      default:            return 1'b0;
    endcase
  endfunction

endpackage

FILE: design/omt_mac.sv
// ----------------------------------------------------------------------------
// omt_mac
// Shared signed multiply-accumulate unit, one product per cycle.
// ----------------------------------------------------------------------------
module omt_mac (
  input  logic                      clk,
  input  omt_pkg::mac_op_t          op,
  output logic [omt_pkg::ACC_W-1:0] acc
);
  import omt_pkg::*;

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   base;

  assign prod = $signed(op.a) * $signed(op.b);
  assign base = op.clr ? '0 : $signed(acc);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= op.sub ? base - ACC_W'(prod) : base + ACC_W'(prod);
    end
  end

endmodule

FILE: design/obstacle_merge_table.sv
// ----------------------------------------------------------------------------
// obstacle_merge_table
// Obstacle table with frame transform, nearest-entry merge, clear and dump.
// ----------------------------------------------------------------------------
// One item is taken at a time. In an integrate, every product of the two frame
// transforms, of the self distance and of each squared entry distance goes
// through one shared multiply-accumulate unit, and the scan reads the entries
// one at a time from the table memory; a merge adds a read and a rewrite of
// the chosen entry. A dump reads and outputs the entries one after another.
// The next item is taken while a finished result still waits.
module obstacle_merge_table #(
  parameter int MAX_ENTRIES = omt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // obs_x, obs_y, ref_x, ref_y, ref_cos, ref_sin, obs_type, could_be_self
  input  logic [103:0]                   s_tdata,
  // command
  input  logic [omt_pkg::CMD_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // slot, entry_type, field_x, field_y, robot_rel_x, robot_rel_y
  output logic [79:0]                    m_tdata,
  // status
  output logic [omt_pkg::STATUS_W-1:0]   m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [omt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [omt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import omt_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR,
    S_FX0, S_FX1, S_FXR, S_FY0, S_FY1, S_FYR,
    S_RX0, S_RX1, S_RXR, S_RY0, S_RY1, S_RYR,
    S_SN0, S_SN1, S_SNR,
    S_SCAN_RD, S_SCAN_D0, S_SCAN_D1, S_SCAN_CMP,
    S_DECIDE, S_MRD, S_MWR,
    S_DRD, S_DOUT
  } state_t;

  state_t state;

  // configuration
  logic [31:0]      merge_radius_sq;
  logic             reclassify_unknown;
  logic             self_fallen;
  logic [POS_W-1:0] robot_x, robot_y, robot_cos, robot_sin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_radius_sq    <= 32'd250000;
      reclassify_unknown <= 1'b0;
      self_fallen        <= 1'b0;
      robot_x            <= '0;
      robot_y            <= '0;
      robot_cos          <= 16'd16384;
      robot_sin          <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS:     merge_radius_sq    <= cfg_data;
        CFG_RECLASSIFY: reclassify_unknown <= cfg_data[0];
        CFG_FALLEN:     self_fallen        <= cfg_data[0];
        CFG_ROBOT_X:    robot_x            <= cfg_data[POS_W-1:0];
        CFG_ROBOT_Y:    robot_y            <= cfg_data[POS_W-1:0];
        CFG_ROBOT_COS:  robot_cos          <= cfg_data[POS_W-1:0];
        CFG_ROBOT_SIN:  robot_sin          <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // item and working registers
  logic [POS_W-1:0]  ox, oy, px, py, pc, ps;
  logic [KIND_W-1:0] kind;
  logic              maybe_self;
  logic [POS_W-1:0]  fx, fy, rx, ry;
  logic [DIST_W-1:0] self_d, best;
  logic              found;
  logic [IDX_W-1:0]  best_slot, idx;
  logic [KIND_W-1:0] best_kind;
  logic [CNT_W-1:0]  count;

  // output word
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [KIND_W-1:0]   out_kind;
  logic [POS_W-1:0]    out_fx, out_fy, out_rx, out_ry;

  assign m_tdata = {7'd0, out_ry, out_rx, out_fy, out_fx, out_kind, out_slot};
  assign m_tuser = out_status;
  assign s_tready = (state == S_IDLE);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // table memory
  entry_t           mem [MAX_ENTRIES];
  entry_t           rd;
  logic             rd_en, mem_we;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd <= mem[rd_addr];
    end
  end

  // shared multiply-accumulate
  mac_op_t          mop;
  logic [ACC_W-1:0] acc;

  omt_mac u_mac (
    .clk (clk),
    .op  (mop),
    .acc (acc)
  );

  logic [POS_W:0] dxr, dyr, ex, ey;
  assign dxr = {fx[POS_W-1], fx} - {robot_x[POS_W-1], robot_x};
  assign dyr = {fy[POS_W-1], fy} - {robot_y[POS_W-1], robot_y};
  assign ex  = {rx[POS_W-1], rx} - {rd.rx[POS_W-1], rd.rx};
  assign ey  = {ry[POS_W-1], ry} - {rd.ry[POS_W-1], rd.ry};

  function automatic logic [MUL_W-1:0] sx(input logic [POS_W:0] v);
    return {v[POS_W], v};
  endfunction

  function automatic logic [MUL_W-1:0] sx16(input logic [POS_W-1:0] v);
    return {{2{v[POS_W-1]}}, v};
  endfunction

  function automatic logic [POS_W-1:0] half(input logic [POS_W-1:0] a,
                                            input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    return s[POS_W:1];
  endfunction

  logic [KIND_W:0]  mk;
  logic             self_hit, full;
  logic [POS_W-1:0] round_acc;
  logic [POS_W:0]   fsum;
  entry_t           merged;

  assign mk        = merge_kind(kind, rd.kind, reclassify_unknown);
  assign self_hit  = maybe_self && (self_d < best) && may_be_self(kind, self_fallen);
  assign full      = (count >= CNT_W'(MAX_ENTRIES));
  assign round_acc = round_q14(acc);
  assign fsum      = {round_acc[POS_W-1], round_acc} +
                     {(state == S_FXR) ? {px[POS_W-1], px} : {py[POS_W-1], py}};
  assign merged    = '{kind: best_kind, fx: half(rd.fx, fx), fy: half(rd.fy, fy),
                       rx: half(rd.rx, rx), ry: half(rd.ry, ry)};

  // a result word is loaded this cycle
  logic out_load;

  always_comb begin
    out_load = 1'b0;
    unique case (state)
      S_CLR, S_MWR, S_DOUT: out_load = out_free;
      S_DECIDE: out_load = out_free && !(found && !self_hit && best_kind != K_GOAL);
      default: ;
    endcase
  end

  always_comb begin
    mop     = '0;
    rd_en   = 1'b0;
    rd_addr = idx;
    mem_we  = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = '{kind: kind, fx: fx, fy: fy, rx: rx, ry: ry};
    unique case (state)
      S_FX0: mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, a: sx16(pc), b: sx16(ox)};
      S_FX1: mop = '{en: 1'b1, clr: 1'b0, sub: 1'b1, a: sx16(ps), b: sx16(oy)};
      S_FY0: mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, a: sx16(ps), b: sx16(ox)};
      S_FY1: mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, a: sx16(pc), b: sx16(oy)};
      S_RX0: mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, a: sx16(robot_cos), b: sx(dxr)};
      S_RX1: mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, a: sx16(robot_sin), b: sx(dyr)};
      S_RY0: mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, a: sx16(robot_cos), b: sx(dyr)};
      S_RY1: mop = '{en: 1'b1, clr: 1'b0, sub: 1'b1, a: sx16(robot_sin), b: sx(dxr)};
      S_SN0: mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, a: sx16(rx), b: sx16(rx)};
      S_SN1: mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, a: sx16(ry), b: sx16(ry)};
      S_SCAN_RD, S_DRD: rd_en = 1'b1;
      S_SCAN_D0: mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, a: sx(ex), b: sx(ex)};
      S_SCAN_D1: mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, a: sx(ey), b: sx(ey)};
      S_MRD: begin
        rd_en   = 1'b1;
        rd_addr = best_slot;
      end
      S_DECIDE: begin
        mem_we = out_free && !self_hit && !found && !full;
      end
      S_MWR: begin
        mem_we  = out_free;
        wr_addr = best_slot;
        wr_data = merged;
      end
      default: ;
    endcase
  end

  logic last_idx;
  assign last_idx = (CNT_W'(idx) + CNT_W'(1) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ox         <= s_tdata[15:0];
            oy         <= s_tdata[31:16];
            px         <= s_tdata[47:32];
            py         <= s_tdata[63:48];
            pc         <= s_tdata[79:64];
            ps         <= s_tdata[95:80];
            kind       <= (s_tdata[99:96] > K_F_TEAM) ? K_UNKNOWN : s_tdata[99:96];
            maybe_self <= s_tdata[100];
            idx        <= '0;
            case (s_tuser)
              CMD_CLEAR:     state <= S_CLR;
              CMD_INTEGRATE: state <= S_FX0;
              CMD_DUMP:      state <= (count == '0) ? S_IDLE : S_DRD;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          if (out_free) begin
            count      <= '0;
            m_tlast    <= 1'b1;
            out_status <= ST_CLEARED;
            out_slot   <= '0;
            out_kind   <= K_UNKNOWN;
            out_fx     <= '0;
            out_fy     <= '0;
            out_rx     <= '0;
            out_ry     <= '0;
            state      <= S_IDLE;
          end
        end
        S_FX0: state <= S_FX1;
        S_FX1: state <= S_FXR;
        S_FXR: begin
          fx    <= sat17(fsum);
          state <= S_FY0;
        end
        S_FY0: state <= S_FY1;
        S_FY1: state <= S_FYR;
        S_FYR: begin
          fy    <= sat17(fsum);
          state <= S_RX0;
        end
        S_RX0: state <= S_RX1;
        S_RX1: state <= S_RXR;
        S_RXR: begin
          rx    <= round_acc;
          state <= S_RY0;
        end
        S_RY0: state <= S_RY1;
        S_RY1: state <= S_RYR;
        S_RYR: begin
          ry    <= round_acc;
          state <= S_SN0;
        end
        S_SN0: state <= S_SN1;
        S_SN1: state <= S_SNR;
        S_SNR: begin
          self_d    <= acc[DIST_W-1:0];
          best      <= DIST_W'(merge_radius_sq);
          found     <= 1'b0;
          best_slot <= '0;
          best_kind <= K_UNKNOWN;
          state     <= (count == '0) ? S_DECIDE : S_SCAN_RD;
        end
        S_SCAN_RD: state <= S_SCAN_D0;
        S_SCAN_D0: state <= S_SCAN_D1;
        S_SCAN_D1: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          // strict compare keeps the earlier entry on a tie
          if (acc[DIST_W-1:0] < best && mk[KIND_W]) begin
            found     <= 1'b1;
            best      <= acc[DIST_W-1:0];
            best_slot <= idx;
            best_kind <= mk[KIND_W-1:0];
          end
          idx   <= idx + 1'b1;
          state <= last_idx ? S_DECIDE : S_SCAN_RD;
        end
        S_DECIDE: begin
          if (found && !self_hit && best_kind != K_GOAL) begin
            state <= S_MRD;
          end else if (out_free) begin
            m_tlast  <= 1'b1;
            out_kind <= kind;
            out_fx   <= fx;
            out_fy   <= fy;
            out_rx   <= rx;
            out_ry   <= ry;
            out_slot <= '0;
            state    <= S_IDLE;
            if (self_hit) begin
              out_status <= ST_DROP_SELF;
            end else if (found) begin
              out_status <= ST_DROP_GOAL;
              out_slot   <= SLOT_W'(best_slot);
              out_kind   <= best_kind;
            end else if (full) begin
              out_status <= ST_FULL;
            end else begin
              out_status <= ST_ADDED;
              out_slot   <= SLOT_W'(count);
              count      <= count + 1'b1;
            end
          end
        end
        S_MRD: state <= S_MWR;
        S_MWR: begin
          if (out_free) begin
            m_tlast    <= 1'b1;
            out_status <= ST_MERGED;
            out_slot   <= SLOT_W'(best_slot);
            out_kind   <= merged.kind;
            out_fx     <= merged.fx;
            out_fy     <= merged.fy;
            out_rx     <= merged.rx;
            out_ry     <= merged.ry;
            state      <= S_IDLE;
          end
        end
        S_DRD: state <= S_DOUT;
        S_DOUT: begin
          if (out_free) begin
            m_tlast    <= last_idx;
            out_status <= ST_DUMP;
            out_slot   <= SLOT_W'(idx);
            out_kind   <= rd.kind;
            out_fx     <= rd.fx;
            out_fy     <= rd.fy;
            out_rx     <= rd.rx;
            out_ry     <= rd.ry;
            idx        <= idx + 1'b1;
            state      <= last_idx ? S_IDLE : S_DRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  // the scan only looks at filled entries
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN_CMP |-> CNT_W'(idx) < count)
    else $error("scan index past entry count");

  // a merge rewrites an entry that exists
  a_merge_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWR && mem_we) |-> CNT_W'(best_slot) < count)
    else $error("merge into an empty slot");

  // an append grows the table by exactly one
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && mem_we) |=> count == $past(count) + 1'b1)
    else $error("append did not bump entry count");

endmodule
